// ----- rtl/mlfq_pkg.sv -----
// shared types and constants for the three-level feedback scheduler
// no dependencies
package mlfq_pkg;
	localparam int MaxProcs = 32;
	localparam int NumLevels = 3;
	localparam int PidW = 6;
	localparam int IdxW = $clog2(MaxProcs);
	localparam int CntW = $clog2(MaxProcs + 1);
	localparam int QAddrW = $clog2(NumLevels * MaxProcs);
	localparam logic [1:0] NoLevel = 2'd3;

	typedef enum logic [1:0] {
		OP_ARRIVE = 2'd0,
		OP_PICK = 2'd1,
		OP_TICK = 2'd2,
		OP_DONE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_Q0 = 2'd0,
		REG_Q1 = 2'd1,
		REG_Q2 = 2'd2,
		REG_BOOST = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [1:0] op;
		logic [PidW-1:0] pid;
		logic [19:0] tick;
	} item_t;

	typedef struct packed {
		logic [PidW-1:0] selected_pid;
		logic [1:0] selected_level;
		logic boosted;
	} result_t;

	typedef struct packed {
		logic [1:0] index;
		logic [15:0] data;
	} cfg_t;

	// queue memory address of slot idx of level lv
	function automatic logic [QAddrW-1:0] qaddr(input logic [1:0] lv, input logic [IdxW-1:0] idx);
		qaddr = QAddrW'(lv) * QAddrW'(MaxProcs) + QAddrW'(idx);
	endfunction

	function automatic logic [IdxW-1:0] wrap_inc(input logic [IdxW-1:0] v);
		wrap_inc = (32'(v) == MaxProcs - 1) ? '0 : v + 1'b1;
	endfunction

	function automatic logic [IdxW-1:0] wrap_dec(input logic [IdxW-1:0] v);
		wrap_dec = (v == '0) ? IdxW'(MaxProcs - 1) : v - 1'b1;
	endfunction
endpackage

// ----- rtl/mlfq_if.sv -----
// valid/ready channel interfaces for items, results and configuration writes
// depends on mlfq_pkg
interface mlfq_item_if;
	import mlfq_pkg::*;
	logic valid;
	logic ready;
	item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface mlfq_result_if;
	import mlfq_pkg::*;
	logic valid;
	logic ready;
	result_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface mlfq_cfg_if;
	import mlfq_pkg::*;
	logic valid;
	logic ready;
	cfg_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ----- rtl/mlfq_ram.sv -----
// generic single-port-write ram with registered read
// no dependencies
module mlfq_ram #(
	parameter int Width = 8,
	parameter int Depth = 32
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] waddr,
	input logic [Width-1:0] wdata,
	input logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// ----- rtl/mlfq_mod.sv -----
// boost test: tick modulo boost interval by restoring shift-subtract, one bit per cycle
// depends on mlfq_pkg
module mlfq_mod (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [19:0] dividend,
	input logic [15:0] divisor,
	output logic busy,
	output logic zero_rem
);
	import mlfq_pkg::*;
	logic [16:0] rem_q;
	logic [19:0] shf_q;
	logic [4:0] cnt_q;
	logic [16:0] trial;

	assign trial = {rem_q[15:0], shf_q[19]} - {1'b0, divisor};
	assign zero_rem = (rem_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy <= 1'b1;
			cnt_q <= 5'd20;
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == 5'd1) busy <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			shf_q <= dividend;
		end else if (busy) begin
			shf_q <= {shf_q[18:0], 1'b0};
			if (!trial[16]) rem_q <= trial;
			else rem_q <= {rem_q[15:0], shf_q[19]};
		end
	end
endmodule

// ----- rtl/mlfq_process_scheduler.sv -----
// Three-level round-robin feedback scheduler.
// Channels: item (op, pid, tick), result (selected_pid, selected_level,
// boosted) and a configuration write channel (index 0..2 quanta, 3 boost
// interval). Each accepted item gives exactly one result.
// From item transaction to result valid: arrival and tick end pass through
// S_OUT, a tick that ends the slice through S_SEL first; a pick waits for
// the serial remainder unit for the boost test, then S_SEL and, for a new
// selection, a queue memory read (S_PRD, S_POP); a boosted pick walks the
// live list with S_BRD and S_BPUT per entry, completion with S_CRD and S_CPUT.
// One item is in flight at a time; item ready is low until the result
// transaction is done, so the next item is taken in the cycle after it at the
// earliest. If the receiver stalls, the result stays in the output register
// and the next item waits.
// Reset clears all control state, quanta to 2/4/8, boost interval to 50;
// memories need no clearing since only written entries are read.
module mlfq_process_scheduler (
	input logic clk,
	input logic arst_n,
	mlfq_item_if.sink item,
	mlfq_result_if.source result,
	mlfq_cfg_if.sink cfg
);
	import mlfq_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE = 11'b00000000001,
		S_DIV = 11'b00000000010,
		S_BST = 11'b00000000100,
		S_BRD = 11'b00000001000,
		S_BPUT = 11'b00000010000,
		S_SEL = 11'b00000100000,
		S_PRD = 11'b00001000000,
		S_POP = 11'b00010000000,
		S_CRD = 11'b00100000000,
		S_CPUT = 11'b01000000000,
		S_OUT = 11'b10000000000
	} state_t;

	state_t state_q;
	item_t it_q;
	logic [7:0] quant_q [NumLevels];
	logic [15:0] boost_q;
	logic [IdxW-1:0] head_q [NumLevels];
	logic [CntW-1:0] count_q [NumLevels];
	logic [7:0] saved_q [NumLevels];
	logic [PidW-1:0] run_pid_q;
	logic [1:0] run_lvl_q;
	logic [7:0] slice_q;
	logic [CntW-1:0] live_cnt_q;
	logic [CntW-1:0] rd_q, wr_q;
	logic boosted_q;
	logic [1:0] top_q;
	logic [PidW-1:0] bst_run_q;

	// queue memory
	logic q_we;
	logic [QAddrW-1:0] q_waddr, q_raddr;
	logic [PidW-1:0] q_wdata, q_rdata;
	// live list memory
	logic l_we;
	logic [IdxW-1:0] l_waddr, l_raddr;
	logic [PidW-1:0] l_wdata, l_rdata;

	mlfq_ram #(.Width(PidW), .Depth(NumLevels * MaxProcs)) u_qram (
		.clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
		.raddr(q_raddr), .rdata(q_rdata)
	);
	mlfq_ram #(.Width(PidW), .Depth(MaxProcs)) u_lram (
		.clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
		.raddr(l_raddr), .rdata(l_rdata)
	);

	logic div_start, div_busy, div_zero;
	mlfq_mod u_mod (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(item.data.tick),
		.divisor(boost_q), .busy(div_busy), .zero_rem(div_zero)
	);

	function automatic logic [7:0] qnt(input logic [7:0] q);
		qnt = (q == '0) ? 8'd1 : q;
	endfunction

	logic [1:0] top;
	logic full_live;
	always_comb begin
		priority if (count_q[0] != '0) top = 2'd0;
		else if (count_q[1] != '0) top = 2'd1;
		else if (count_q[2] != '0) top = 2'd2;
		else top = NoLevel;
	end
	assign full_live = (32'(live_cnt_q) >= MaxProcs);

	assign item.ready = (state_q == S_IDLE) && !result.valid;
	assign cfg.ready = 1'b1;
	assign div_start = (state_q == S_IDLE) && item.valid && item.ready
		&& (item.data.op == OP_PICK);

	logic [1:0] nl;
	logic [IdxW-1:0] tail_idx;
	always_comb begin
		nl = (run_lvl_q >= 2'd1) ? 2'd2 : run_lvl_q + 2'd1;
		tail_idx = '0;
		q_we = 1'b0;
		q_waddr = '0;
		q_wdata = run_pid_q;
		q_raddr = qaddr(top_q, head_q[top_q[1:0] == NoLevel ? 2'd0 : top_q]);
		l_we = 1'b0;
		l_waddr = IdxW'(live_cnt_q);
		l_wdata = it_q.pid;
		l_raddr = IdxW'(rd_q);
		unique case (state_q)
			S_IDLE: begin
				if (item.valid && item.ready && item.data.op == OP_ARRIVE
					&& item.data.pid != '0 && 32'(item.data.pid) <= MaxProcs) begin
					tail_idx = IdxW'((32'(head_q[0]) + 32'(count_q[0])) % MaxProcs);
					q_we = (32'(count_q[0]) < MaxProcs);
					q_waddr = qaddr(2'd0, tail_idx);
					q_wdata = item.data.pid;
					l_we = !full_live;
					l_wdata = item.data.pid;
				end
			end
			S_BPUT: begin
				if (l_rdata != bst_run_q && 32'(count_q[0]) < MaxProcs) begin
					q_we = 1'b1;
					q_waddr = qaddr(2'd0, IdxW'(count_q[0]));
					q_wdata = l_rdata;
				end
			end
			S_BST: begin
				// running process goes in front of the rebuilt level 0
				if (run_pid_q != '0) begin
					q_we = (32'(count_q[0]) < MaxProcs);
					q_waddr = qaddr(2'd0, wrap_dec(head_q[0]));
				end
			end
			S_SEL: begin
				// tail push on slice expiry, or head push for preempt
				if (it_q.op == OP_TICK) begin
					tail_idx = IdxW'((32'(head_q[nl]) + 32'(count_q[nl])) % MaxProcs);
					q_we = (32'(count_q[nl]) < MaxProcs);
					q_waddr = qaddr(nl, tail_idx);
				end else if (run_pid_q != '0 && top != NoLevel && top < run_lvl_q) begin
					q_we = (32'(count_q[run_lvl_q]) < MaxProcs);
					q_waddr = qaddr(run_lvl_q, wrap_dec(head_q[run_lvl_q]));
				end
			end
			S_CPUT: begin
				if (l_rdata != run_pid_q) begin
					l_we = 1'b1;
					l_waddr = IdxW'(wr_q);
					l_wdata = l_rdata;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			quant_q[0] <= 8'd2;
			quant_q[1] <= 8'd4;
			quant_q[2] <= 8'd8;
			boost_q <= 16'd50;
			for (int l = 0; l < NumLevels; l++) begin
				head_q[l] <= '0;
				count_q[l] <= '0;
				saved_q[l] <= '0;
			end
			run_pid_q <= '0;
			run_lvl_q <= NoLevel;
			slice_q <= '0;
			live_cnt_q <= '0;
			rd_q <= '0;
			wr_q <= '0;
			boosted_q <= 1'b0;
			top_q <= '0;
			bst_run_q <= '0;
			result.valid <= 1'b0;
			it_q <= '0;
		end else begin
			if (cfg.valid) begin
				unique case (reg_idx_t'(cfg.data.index))
					REG_Q0: quant_q[0] <= cfg.data.data[7:0];
					REG_Q1: quant_q[1] <= cfg.data.data[7:0];
					REG_Q2: quant_q[2] <= cfg.data.data[7:0];
					REG_BOOST: boost_q <= cfg.data.data;
				endcase
			end
			if (result.valid && result.ready) result.valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (item.valid && item.ready) begin
						it_q <= item.data;
						boosted_q <= 1'b0;
						unique case (op_t'(item.data.op))
							OP_ARRIVE: begin
								if (item.data.pid != '0 && 32'(item.data.pid) <= MaxProcs) begin
									if (32'(count_q[0]) < MaxProcs) count_q[0] <= count_q[0] + 1'b1;
									if (!full_live) live_cnt_q <= live_cnt_q + 1'b1;
								end
								state_q <= S_OUT;
							end
							OP_PICK: state_q <= S_DIV;
							OP_TICK: begin
								if (item.data.pid != '0 && run_pid_q != '0) begin
									if (slice_q <= 8'd1) begin
										slice_q <= '0;
										state_q <= S_SEL;
									end else begin
										slice_q <= slice_q - 1'b1;
										state_q <= S_OUT;
									end
								end else state_q <= S_OUT;
							end
							OP_DONE: begin
								rd_q <= '0;
								wr_q <= '0;
								if (run_pid_q != '0 && live_cnt_q != '0) state_q <= S_CRD;
								else begin
									run_pid_q <= '0;
									run_lvl_q <= NoLevel;
									slice_q <= '0;
									state_q <= S_OUT;
								end
							end
						endcase
					end
				end
				S_DIV: begin
					if (!div_busy) begin
						if (it_q.tick != '0 && boost_q != '0 && div_zero) begin
							boosted_q <= 1'b1;
							bst_run_q <= run_pid_q;
							for (int l = 0; l < NumLevels; l++) begin
								head_q[l] <= '0;
								count_q[l] <= '0;
								saved_q[l] <= '0;
							end
							rd_q <= '0;
							state_q <= (live_cnt_q != '0) ? S_BRD : S_BST;
						end else state_q <= S_SEL;
					end
				end
				S_BRD: state_q <= S_BPUT;
				S_BPUT: begin
					if (l_rdata != bst_run_q && 32'(count_q[0]) < MaxProcs)
						count_q[0] <= count_q[0] + 1'b1;
					rd_q <= rd_q + 1'b1;
					state_q <= (rd_q + 1'b1 == live_cnt_q) ? S_BST : S_BRD;
				end
				S_BST: begin
					// running process returns to the head of level 0 with a full quantum
					if (run_pid_q != '0) begin
						if (32'(count_q[0]) < MaxProcs) begin
							head_q[0] <= wrap_dec(head_q[0]);
							count_q[0] <= count_q[0] + 1'b1;
							saved_q[0] <= qnt(quant_q[0]);
						end
						run_pid_q <= '0;
						run_lvl_q <= NoLevel;
						slice_q <= '0;
					end
					state_q <= S_SEL;
				end
				S_SEL: begin
					if (it_q.op == OP_TICK) begin
						if (32'(count_q[nl]) < MaxProcs) count_q[nl] <= count_q[nl] + 1'b1;
						run_pid_q <= '0;
						run_lvl_q <= NoLevel;
						slice_q <= '0;
						state_q <= S_OUT;
					end else if (run_pid_q != '0 && top != NoLevel && top < run_lvl_q) begin
						if (32'(count_q[run_lvl_q]) < MaxProcs) begin
							head_q[run_lvl_q] <= wrap_dec(head_q[run_lvl_q]);
							count_q[run_lvl_q] <= count_q[run_lvl_q] + 1'b1;
							saved_q[run_lvl_q] <= slice_q;
						end
						run_pid_q <= '0;
						run_lvl_q <= NoLevel;
						slice_q <= '0;
						top_q <= top;
						state_q <= S_PRD;
					end else if (run_pid_q != '0 && slice_q != '0) begin
						state_q <= S_OUT;
					end else if (top == NoLevel) begin
						run_pid_q <= '0;
						run_lvl_q <= NoLevel;
						slice_q <= '0;
						state_q <= S_OUT;
					end else begin
						top_q <= top;
						state_q <= S_PRD;
					end
				end
				S_PRD: state_q <= S_POP;
				S_POP: begin
					run_pid_q <= q_rdata;
					head_q[top_q] <= wrap_inc(head_q[top_q]);
					count_q[top_q] <= count_q[top_q] - 1'b1;
					slice_q <= (saved_q[top_q] != '0) ? saved_q[top_q] : qnt(quant_q[top_q]);
					saved_q[top_q] <= '0;
					run_lvl_q <= top_q;
					state_q <= S_OUT;
				end
				S_CRD: state_q <= S_CPUT;
				S_CPUT: begin
					if (l_rdata != run_pid_q) wr_q <= wr_q + 1'b1;
					rd_q <= rd_q + 1'b1;
					if (rd_q + 1'b1 == live_cnt_q) begin
						live_cnt_q <= (l_rdata != run_pid_q) ? wr_q + 1'b1 : wr_q;
						run_pid_q <= '0;
						run_lvl_q <= NoLevel;
						slice_q <= '0;
						state_q <= S_OUT;
					end else state_q <= S_CRD;
				end
				S_OUT: begin
					result.valid <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT) begin
			result.data.selected_pid <= run_pid_q;
			result.data.selected_level <= run_lvl_q;
			result.data.boosted <= boosted_q;
		end
	end
endmodule
